// ===== design/wbps_pkg.sv =====
`default_nettype none
package wbps_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int HIST_DEPTH  = 16;
   localparam int CHUNK_BYTES = 4096;
   localparam int CHUNK_LOG   = $clog2(CHUNK_BYTES);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 3;

   localparam logic [4:0]  RESET_PATTERN_LENGTH = 5'd1;
   localparam logic [15:0] RESET_MAX_MATCHES    = 16'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_WILDCARD_MASK  = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_MAX_MATCHES    = 3'd4,
      CSR_BASE_ADDRESS   = 3'd5
   } csr_index_type;

   typedef enum logic {
      BACK_FIRST   = 1'b0,
      BACK_SUMMARY = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] wildcard_mask;
      logic [4:0]  pattern_length;
      logic [15:0] max_matches;
      logic [63:0] base_address;
   } cfg_type;

   // one queued request that produces results
   typedef struct packed {
      logic        hit;
      logic        is_final;
      logic [32:0] start_offset;   // signed offset of the match start
      logic [15:0] count;
   } entry_type;

endpackage
`default_nettype wire

// ===== design/wbps_req_if.sv =====
`default_nettype none
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       readable;
   logic       final_byte;

   modport source (output valid, data_byte, readable, final_byte, input ready);
   modport sink   (input valid, data_byte, readable, final_byte, output ready);
endinterface
`default_nettype wire

// ===== design/wbps_rsp_if.sv =====
`default_nettype none
interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] match_address;
   logic [15:0] found_count;
   logic        is_summary;
   logic        last_of_run;

   modport source (output valid, match_address, found_count, is_summary, last_of_run,
                   input ready);
   modport sink   (input valid, match_address, found_count, is_summary, last_of_run,
                   output ready);
endinterface
`default_nettype wire

// ===== design/wbps_csr_if.sv =====
`default_nettype none
interface wbps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wbps_pkg::CSR_INDEX_W-1:0] index;
   logic [63:0]                       wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== design/wildcard_byte_pattern_scanner.sv =====
// the first result of a request goes through the result queue and then into the
//   result register of the back end, which loads when it is empty or being read
// throughput: one request per cycle while the queue is not full; a request with a match
//   and a final byte sends a match, then a summary, through the single result register
// the four-entry result queue absorbs result-side stalls while requests keep coming
// reset: synchronous, active high; registers return to their reset values, history fill,
//   offset, match count, queue and result register are cleared
`default_nettype none
module wildcard_byte_pattern_scanner (
   input  wire        clock,
   input  wire        reset,
   wbps_req_if.sink   req_chan,
   wbps_rsp_if.source rsp_chan,
   wbps_csr_if.sink   csr_chan
);

   // configuration registers
   wbps_pkg::cfg_type cfg_ff;

   // queue between scan front end and result back end
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_not_empty;
   wbps_pkg::entry_type q_entry;
   wbps_pkg::entry_type q_head;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= 64'd0;
         cfg_ff.pattern_high   <= 64'd0;
         cfg_ff.wildcard_mask  <= 16'd0;
         cfg_ff.pattern_length <= wbps_pkg::RESET_PATTERN_LENGTH;
         cfg_ff.max_matches    <= wbps_pkg::RESET_MAX_MATCHES;
         cfg_ff.base_address   <= 64'd0;
      end else if (csr_chan.valid) begin
         // writes to unused indexes are dropped
         unique case (csr_chan.index)
            wbps_pkg::CSR_PATTERN_LOW:    cfg_ff.pattern_low    <= csr_chan.wdata;
            wbps_pkg::CSR_PATTERN_HIGH:   cfg_ff.pattern_high   <= csr_chan.wdata;
            wbps_pkg::CSR_WILDCARD_MASK:  cfg_ff.wildcard_mask  <= csr_chan.wdata[15:0];
            wbps_pkg::CSR_PATTERN_LENGTH: cfg_ff.pattern_length <= csr_chan.wdata[4:0];
            wbps_pkg::CSR_MAX_MATCHES:    cfg_ff.max_matches    <= csr_chan.wdata[15:0];
            wbps_pkg::CSR_BASE_ADDRESS:   cfg_ff.base_address   <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   // front end: history shift, parallel compare, offset and match count
   wbps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .data_byte  (req_chan.data_byte),
      .readable   (req_chan.readable),
      .final_byte (req_chan.final_byte),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // only requests with a match or a final byte are queued
   wbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // back end: address add and result sequencing into the output register
   wbps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .base_address  (cfg_ff.base_address),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .match_address (rsp_chan.match_address),
      .found_count   (rsp_chan.found_count),
      .is_summary    (rsp_chan.is_summary),
      .last_of_run   (rsp_chan.last_of_run)
   );

   // the queue never takes an entry while full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue push while full");

   // the queue is never popped while empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("queue pop while empty");

   // a summary always closes the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_summary |-> rsp_chan.last_of_run)
      else $error("summary not marked last");

   // a match that is not last is followed directly by its summary
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.is_summary && !rsp_chan.last_of_run
      |=> rsp_chan.valid && rsp_chan.is_summary)
      else $error("missing summary after final match");

endmodule
`default_nettype wire

// ===== design/wbps_front.sv =====
`default_nettype none
module wbps_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire [7:0]            data_byte,
   input  wire                  readable,
   input  wire                  final_byte,
   input  wire wbps_pkg::cfg_type cfg,
   input  wire                  q_full,
   output logic                 q_push,
   output wbps_pkg::entry_type  q_entry
);

   logic [wbps_pkg::HIST_DEPTH-1:0][7:0] hist_ff, hist_in;
   logic [wbps_pkg::HIST_DEPTH-1:0][7:0] hist_shift;
   logic [wbps_pkg::HIST_DEPTH-1:0][7:0] pat_bytes;
   logic [4:0]  fill_ff, fill_in;
   logic [31:0] offset_ff, offset_in;
   logic [15:0] total_ff, total_in;

   logic        accept;
   logic        active;
   logic [4:0]  fill_base;
   logic [4:0]  fill_new;
   logic [4:0]  len;
   logic [3:0]  len_m1;
   logic        bytes_ok;
   logic        hit;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign active   = total_ff < cfg.max_matches;

   // chunk boundary restarts the history
   assign fill_base = (offset_ff[wbps_pkg::CHUNK_LOG-1:0] == '0) ? 5'd0 : fill_ff;
   assign fill_new  = (fill_base < 5'(wbps_pkg::HIST_DEPTH)) ? fill_base + 5'd1
                                                             : 5'(wbps_pkg::HIST_DEPTH);

   always_comb begin
      if (cfg.pattern_length == 5'd0) begin
         len = 5'd1;
      end else if (cfg.pattern_length > 5'(wbps_pkg::MAX_PATTERN)) begin
         len = 5'(wbps_pkg::MAX_PATTERN);
      end else begin
         len = cfg.pattern_length;
      end
   end
   assign len_m1 = 4'(len - 5'd1);

   assign hist_shift = {hist_ff[wbps_pkg::HIST_DEPTH-2:0], data_byte};
   assign pat_bytes  = {cfg.pattern_high, cfg.pattern_low};

   // all pattern positions compared in parallel
   always_comb begin
      bytes_ok = 1'b1;
      for (int j = 0; j < wbps_pkg::HIST_DEPTH; j++) begin
         if ((5'(j) < len) && !cfg.wildcard_mask[j] &&
             (hist_shift[len_m1 - 4'(j)] != pat_bytes[j])) begin
            bytes_ok = 1'b0;
         end
      end
   end

   assign hit = active && readable && (fill_new >= len) && bytes_ok;

   always_comb begin
      hist_in   = hist_ff;
      fill_in   = fill_ff;
      offset_in = offset_ff;
      total_in  = total_ff;
      if (accept) begin
         offset_in = offset_ff + 32'd1;
         if (active) begin
            hist_in = hist_shift;
            if (!readable || hit) begin
               fill_in = 5'd0;
            end else begin
               fill_in = fill_new;
            end
            if (hit) begin
               total_in = total_ff + 16'd1;
            end
         end
         if (final_byte) begin
            offset_in = 32'd0;
            fill_in   = 5'd0;
            total_in  = 16'd0;
         end
      end
   end

   assign q_push                = accept && (hit || final_byte);
   assign q_entry.hit           = hit;
   assign q_entry.is_final      = final_byte;
   assign q_entry.start_offset  = {1'b0, offset_ff} - {29'd0, len_m1};
   assign q_entry.count         = hit ? total_ff + 16'd1 : total_ff;

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      if (reset) begin
         fill_ff   <= 5'd0;
         offset_ff <= 32'd0;
         total_ff  <= 16'd0;
      end else begin
         fill_ff   <= fill_in;
         offset_ff <= offset_in;
         total_ff  <= total_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/wbps_queue.sv =====
`default_nettype none
module wbps_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire wbps_pkg::entry_type push_entry,
   output logic                 full,
   input  wire                  pop,
   output logic                 not_empty,
   output wbps_pkg::entry_type  head
);

   wbps_pkg::entry_type slots_ff [wbps_pkg::QUEUE_DEPTH];
   logic [wbps_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [wbps_pkg::QPTR_W:0]   count_ff, count_in;

   assign full      = count_ff == (wbps_pkg::QPTR_W+1)'(wbps_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/wbps_back.sv =====
`default_nettype none
module wbps_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_not_empty,
   input  wire wbps_pkg::entry_type q_head,
   output logic                 q_pop,
   input  wire [63:0]           base_address,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic [63:0]          match_address,
   output logic [15:0]          found_count,
   output logic                 is_summary,
   output logic                 last_of_run
);

   wbps_pkg::back_state_type state_ff, state_in, state_next;
   logic        valid_ff, valid_in;
   logic [63:0] addr_ff, addr_in, addr_next;
   logic [15:0] count_ff;
   logic        summary_ff, summary_next;
   logic        last_ff, last_next;
   logic        pop_next;
   logic        load;
   logic        take;

   assign load = !valid_ff || out_ready;
   assign take = load && q_not_empty;

   always_comb begin
      state_next   = wbps_pkg::BACK_FIRST;
      addr_next    = 64'd0;
      summary_next = 1'b1;
      last_next    = 1'b1;
      pop_next     = 1'b1;
      unique case (state_ff)
         wbps_pkg::BACK_FIRST: begin
            if (q_head.hit) begin
               addr_next    = base_address + {{31{q_head.start_offset[32]}},
                                              q_head.start_offset};
               summary_next = 1'b0;
               last_next    = !q_head.is_final;
               pop_next     = !q_head.is_final;
               state_next   = q_head.is_final ? wbps_pkg::BACK_SUMMARY
                                              : wbps_pkg::BACK_FIRST;
            end
         end
         wbps_pkg::BACK_SUMMARY: begin
            state_next = wbps_pkg::BACK_FIRST;
         end
         default: begin
            state_next = wbps_pkg::BACK_FIRST;
         end
      endcase

      state_in = take ? state_next : state_ff;
      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      addr_in  = addr_next;
      q_pop    = take && pop_next;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         addr_ff    <= addr_in;
         count_ff   <= q_head.count;
         summary_ff <= summary_next;
         last_ff    <= last_next;
      end
      if (reset) begin
         state_ff <= wbps_pkg::BACK_FIRST;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid     = valid_ff;
   assign match_address = addr_ff;
   assign found_count   = count_ff;
   assign is_summary    = summary_ff;
   assign last_of_run   = last_ff;

endmodule
`default_nettype wire
